// ===== sv/mbrp_pkg.sv =====
// Shared types and constants for the Modbus response PDU parser.
`default_nettype none

package mbrp_pkg;

  // Function codes the parser decodes.
  localparam logic [7:0] FC_READ_HOLDING = 8'h03;
  localparam logic [7:0] FC_READ_INPUT   = 8'h04;
  localparam logic [7:0] FC_WRITE_COIL   = 8'h05;
  localparam logic [7:0] FC_WRITE_REG    = 8'h06;

  // Fixed lengths: minimum read, header, single-write response and its data.
  localparam logic [8:0] READ_MIN_LEN    = 9'd3;
  localparam logic [8:0] HDR_LEN         = 9'd2;
  localparam logic [8:0] SINGLE_LEN      = 9'd5;
  localparam logic [7:0] SINGLE_DATA_LEN = 8'd4;

  // Summary status codes.
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_SHORT = 2'd1;
  localparam logic [1:0] STAT_EXC   = 2'd2;
  localparam logic [1:0] STAT_UNSUP = 2'd3;

  // Result kinds.
  localparam logic KIND_WORD    = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  // Output queue depth (power of two) and its pointer width.
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = PTR_W + 1;

  localparam int OUT_DATA_W = 96;

  typedef struct packed {
    logic        kind;
    logic        final_of_run;
    logic [6:0]  word_index;
    logic [15:0] word_value;
    logic [7:0]  resp_func;
    logic [1:0]  status;
    logic        exc_bit;
    logic [7:0]  exc_value;
    logic [7:0]  data_len;
    logic [6:0]  register_count;
    logic [15:0] echo_address;
    logic [15:0] echo_value;
  } res_t;

  // Results produced by one accepted byte, first result in r0.
  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
  } push_t;

  function automatic logic is_read_fc(input logic [7:0] fc);
    return (fc == FC_READ_HOLDING) || (fc == FC_READ_INPUT);
  endfunction

  function automatic logic is_single_fc(input logic [7:0] fc);
    return (fc == FC_WRITE_COIL) || (fc == FC_WRITE_REG);
  endfunction

endpackage

`default_nettype wire

// ===== sv/mbrp_parse.sv =====
// Per-byte PDU decoder: frame state and the results caused by each byte.
`default_nettype none

module mbrp_parse
  import mbrp_pkg::*;
#(
  parameter int MAX_PDU_BYTES = 256
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_fire,
  input  wire logic [7:0] pdu_byte,
  input  wire logic       frame_end,
  output push_t           push
);

  localparam logic [8:0] PDU_LIMIT = 9'((MAX_PDU_BYTES > 256) ? 256 : MAX_PDU_BYTES);

  logic [7:0]  pos_r, pos_nxt, pos_u;
  logic        full_r, full_nxt, full_u;
  logic [7:0]  func_r, func_nxt, func_u;
  logic [7:0]  count_r, count_nxt, count_u;
  logic [7:0]  hold_r, hold_nxt, hold_u;
  logic [15:0] addr_r, addr_nxt, addr_u;
  logic [15:0] val_r, val_nxt, val_u;
  logic [7:0]  exc_r, exc_nxt, exc_u;

  logic [7:0]  data_idx;
  logic        word_ok;
  logic        sum_ok;
  logic [8:0]  len;
  res_t        word_res;
  res_t        sum_res;

  // Field capture for one byte at the current position.
  always_comb begin
    pos_u    = pos_r;
    full_u   = full_r;
    func_u   = func_r;
    count_u  = count_r;
    hold_u   = hold_r;
    addr_u   = addr_r;
    val_u    = val_r;
    exc_u    = exc_r;
    word_ok  = 1'b0;
    data_idx = pos_r - 8'd2;
    if (in_fire && !full_r) begin
      if (pos_r == 8'd0) begin
        func_u = pdu_byte;
      end else if (pos_r == 8'd1) begin
        if (func_r[7]) begin
          exc_u = pdu_byte;
        end else if (is_read_fc(func_r)) begin
          count_u = pdu_byte;
        end else if (is_single_fc(func_r)) begin
          addr_u = {pdu_byte, 8'h00};
        end
      end else if (!func_r[7] && is_read_fc(func_r)) begin
        if (!count_r[0] && (data_idx < count_r)) begin
          if (!data_idx[0]) begin
            hold_u = pdu_byte;
          end else begin
            word_ok = 1'b1;
          end
        end
      end else if (!func_r[7] && is_single_fc(func_r)) begin
        if (pos_r == 8'd2) begin
          addr_u = addr_r | {8'h00, pdu_byte};
        end else if (pos_r == 8'd3) begin
          val_u = {pdu_byte, 8'h00};
        end else if (pos_r == 8'd4) begin
          val_u = val_r | {8'h00, pdu_byte};
        end
      end
      if (({1'b0, pos_r} + 9'd1) >= PDU_LIMIT) begin
        full_u = 1'b1;
      end else begin
        pos_u = pos_r + 8'd1;
      end
    end
  end

  // Register word result.
  always_comb begin
    word_res              = '0;
    word_res.kind         = KIND_WORD;
    word_res.word_index   = data_idx[7:1];
    word_res.word_value   = {hold_r, pdu_byte};
  end

  // End-of-frame summary, built from the state as updated by this byte.
  assign sum_ok = in_fire && frame_end;
  assign len    = full_u ? ({1'b0, pos_u} + 9'd1) : {1'b0, pos_u};

  always_comb begin
    sum_res           = '0;
    sum_res.kind      = KIND_SUMMARY;
    sum_res.resp_func = func_u;
    sum_res.exc_bit   = func_u[7];
    if (len < HDR_LEN) begin
      sum_res.status = STAT_SHORT;
    end else if (func_u[7]) begin
      sum_res.status    = STAT_EXC;
      sum_res.exc_value = exc_u;
    end else if (is_read_fc(func_u)) begin
      if ((len < READ_MIN_LEN) || (len < (HDR_LEN + {1'b0, count_u})) || count_u[0]) begin
        sum_res.status = STAT_SHORT;
      end else begin
        sum_res.status         = STAT_OK;
        sum_res.data_len       = count_u;
        sum_res.register_count = count_u[7:1];
      end
    end else if (is_single_fc(func_u)) begin
      if (len < SINGLE_LEN) begin
        sum_res.status = STAT_SHORT;
      end else begin
        sum_res.status       = STAT_OK;
        sum_res.data_len     = SINGLE_DATA_LEN;
        sum_res.echo_address = addr_u;
        sum_res.echo_value   = val_u;
      end
    end else begin
      sum_res.status = STAT_UNSUP;
    end
  end

  // Order the results; the last one carries the final flag.
  always_comb begin
    push    = '0;
    push.r0 = word_ok ? word_res : sum_res;
    push.r1 = sum_res;
    if (word_ok && sum_ok) begin
      push.n               = 2'd2;
      push.r1.final_of_run = 1'b1;
    end else if (word_ok || sum_ok) begin
      push.n               = 2'd1;
      push.r0.final_of_run = 1'b1;
    end
  end

  // A frame end returns every field to its reset value.
  always_comb begin
    if (sum_ok) begin
      pos_nxt   = '0;
      full_nxt  = 1'b0;
      func_nxt  = '0;
      count_nxt = '0;
      hold_nxt  = '0;
      addr_nxt  = '0;
      val_nxt   = '0;
      exc_nxt   = '0;
    end else begin
      pos_nxt   = pos_u;
      full_nxt  = full_u;
      func_nxt  = func_u;
      count_nxt = count_u;
      hold_nxt  = hold_u;
      addr_nxt  = addr_u;
      val_nxt   = val_u;
      exc_nxt   = exc_u;
    end
  end

  // Frame state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      full_r  <= 1'b0;
      func_r  <= '0;
      count_r <= '0;
      hold_r  <= '0;
      addr_r  <= '0;
      val_r   <= '0;
      exc_r   <= '0;
    end else begin
      pos_r   <= pos_nxt;
      full_r  <= full_nxt;
      func_r  <= func_nxt;
      count_r <= count_nxt;
      hold_r  <= hold_nxt;
      addr_r  <= addr_nxt;
      val_r   <= val_nxt;
      exc_r   <= exc_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== sv/modbus_response_pdu_parser_top.sv =====
// Top level of the Modbus response PDU parser with its output queue.
//
//   Channel | Dir | Handshake            | Payload
//   in_     | in  | in_tvalid/in_tready  | tdata pdu_byte, tlast frame_end
//   out_    | out | out_tvalid/out_tready| tdata result fields, tuser kind,
//           |     |                      | tlast final_of_run
//
// One byte is accepted per cycle while in_tready is high; its results are written
// into a four-word output queue at the same edge and leave it in order on out_.
// A byte that ends a frame after completing a register gives two words,
// so the queue accepts a byte only while two entries are free.
// Reset (synchronous, active low) clears the frame state and empties the queue.
// A stalled output fills the queue until under two entries are free, then holds in_tready low.
`default_nettype none

module modbus_response_pdu_parser_top
  import mbrp_pkg::*;
#(
  parameter int MAX_PDU_BYTES = 256
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [7:0]            in_tdata,   // [7:0] pdu_byte
  input  wire logic                  in_tlast,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [6:0] word_index, [22:7] word_value, [30:23] function byte,
  // [32:31] status, [33] exception flag, [41:34] exception value,
  // [49:42] data length, [56:50] register_count,
  // [72:57] echo_address, [88:73] echo_value, [95:89] zero
  output logic [OUT_DATA_W-1:0]      out_tdata,
  output logic                       out_tuser,  // [0] kind
  output logic                       out_tlast
);

  logic             in_fire;
  logic             out_fire;
  push_t            push;
  res_t             fifo_r [FIFO_DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  res_t             head;

  assign in_tready = (cnt_r <= CNT_W'(FIFO_DEPTH - 2));
  assign in_fire   = in_tvalid && in_tready;
  assign out_fire  = out_tvalid && out_tready;

  mbrp_parse #(
    .MAX_PDU_BYTES(MAX_PDU_BYTES)
  ) u_parse (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .pdu_byte (in_tdata),
    .frame_end(in_tlast),
    .push     (push)
  );

  // Queue pointers and fill count.
  always_comb begin
    wr_nxt  = wr_r + PTR_W'(push.n);
    rd_nxt  = rd_r + PTR_W'(out_fire);
    cnt_nxt = cnt_r + CNT_W'(push.n) - CNT_W'(out_fire);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  // Queue storage, up to two words written per cycle.
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) begin
      fifo_r[wr_r] <= push.r0;
    end
    if (push.n == 2'd2) begin
      fifo_r[wr_r + PTR_W'(1)] <= push.r1;
    end
  end

  // Output packing.
  assign head       = fifo_r[rd_r];
  assign out_tvalid = (cnt_r != '0);
  assign out_tuser  = head.kind;
  assign out_tlast  = head.final_of_run;
  assign out_tdata  = {7'b0, head.echo_value, head.echo_address, head.register_count,
                       head.data_len, head.exc_value, head.exc_bit,
                       head.status, head.resp_func, head.word_value,
                       head.word_index};

  // Checks on the queue and on result ordering.
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(FIFO_DEPTH))
    else $error("output queue count exceeds its depth");

  a_push_needs_fire: assert property (@(posedge clk) disable iff (!rst_n)
    !in_fire |-> (push.n == 2'd0))
    else $error("results pushed without an accepted byte");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n == 2'd2) |-> (push.r0.kind == KIND_WORD && push.r1.kind == KIND_SUMMARY))
    else $error("two results in the wrong order");

  a_end_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && in_tlast) |=> out_tvalid)
    else $error("frame end left no result queued");

endmodule

`default_nettype wire

// ===== sim/tb_mbrp_scoreboard_pkg.sv =====
// Scoreboard class that predicts and checks the result words of the PDU parser.
package tb_mbrp_scoreboard_pkg;
  import mbrp_pkg::*;

  // Largest PDU the parser stores; later bytes of a frame are dropped.
  localparam int PDU_LIMIT  = 256;
  localparam int REPORT_MAX = 10;

  class pdu_scoreboard;
    // Frame state, kept in step with the parser.
    logic [7:0]  byte_pos;
    logic        pdu_full;
    logic [7:0]  func_code;
    logic [7:0]  rd_count;
    logic [7:0]  high_byte;
    logic [15:0] echo_addr;
    logic [15:0] echo_val;
    logic [7:0]  exc_code;

    res_t        expected_results[$];
    int          mismatches;
    int          words_checked;
    int          summaries_checked;

    function new();
      clear_frame();
      mismatches        = 0;
      words_checked     = 0;
      summaries_checked = 0;
    endfunction

    function void clear_frame();
      byte_pos   = '0;
      pdu_full   = 1'b0;
      func_code  = '0;
      rd_count   = '0;
      high_byte  = '0;
      echo_addr  = '0;
      echo_val   = '0;
      exc_code   = '0;
    endfunction

    // Works out the results of one accepted input word and queues them.
    function void note_byte(logic [7:0] b, logic last);
      res_t made [2];
      int   n;
      int   idx;
      int   d;
      int   len;
      logic is_rd;
      logic is_wr;
      n     = 0;
      is_rd = (func_code == FC_READ_HOLDING) || (func_code == FC_READ_INPUT);
      is_wr = (func_code == FC_WRITE_COIL) || (func_code == FC_WRITE_REG);

      // Header and data decoding while the frame still fits.
      if (!pdu_full) begin
        idx = byte_pos;
        if (idx == 0) begin
          func_code = b;
        end else if (idx == 1) begin
          if (func_code[7]) begin
            exc_code = b;
          end else if (is_rd) begin
            rd_count = b;
          end else if (is_wr) begin
            echo_addr = {b, 8'h00};
          end
        end else if (!func_code[7] && is_rd) begin
          d = idx - 2;
          if (!rd_count[0] && d < int'(rd_count)) begin
            if (d % 2 == 0) begin
              high_byte = b;
            end else begin
              made[n]            = '0;
              made[n].kind       = KIND_WORD;
              made[n].word_index = 7'(d / 2);
              made[n].word_value = {high_byte, b};
              n++;
            end
          end
        end else if (!func_code[7] && is_wr) begin
          case (idx)
            2: echo_addr[7:0] = b;
            3: echo_val = {b, 8'h00};
            4: echo_val[7:0] = b;
            default: ;
          endcase
        end
        if (idx + 1 >= PDU_LIMIT) pdu_full = 1'b1;
        else byte_pos = 8'(idx + 1);
      end

      // Summary at the end of the frame.
      if (last) begin
        len               = pdu_full ? int'(byte_pos) + 1 : int'(byte_pos);
        made[n]           = '0;
        made[n].kind      = KIND_SUMMARY;
        made[n].resp_func = func_code;
        made[n].exc_bit   = func_code[7];
        if (len < int'(HDR_LEN)) begin
          made[n].status = STAT_SHORT;
        end else if (func_code[7]) begin
          made[n].status    = STAT_EXC;
          made[n].exc_value = exc_code;
        end else if (is_rd) begin
          if (len < int'(READ_MIN_LEN) || len < int'(HDR_LEN) + int'(rd_count) ||
              rd_count[0]) begin
            made[n].status = STAT_SHORT;
          end else begin
            made[n].status         = STAT_OK;
            made[n].data_len       = rd_count;
            made[n].register_count = rd_count[7:1];
          end
        end else if (is_wr) begin
          if (len < int'(SINGLE_LEN)) begin
            made[n].status = STAT_SHORT;
          end else begin
            made[n].status       = STAT_OK;
            made[n].data_len     = SINGLE_DATA_LEN;
            made[n].echo_address = echo_addr;
            made[n].echo_value   = echo_val;
          end
        end else begin
          made[n].status = STAT_UNSUP;
        end
        n++;
        clear_frame();
      end

      if (n > 0) made[n-1].final_of_run = 1'b1;
      for (int i = 0; i < n; i++) expected_results.push_back(made[i]);
    endfunction

    function void compare(string field, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("Mismatch in %s: expected 0x%0h, got 0x%0h", field, want, got);
      end
    endfunction

    // Checks one accepted output word against the oldest expectation.
    function void check_result(logic [OUT_DATA_W-1:0] data, logic kind, logic last);
      res_t want;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("Unexpected result: kind %0d, last %0d, data 0x%0h", kind, last, data);
        return;
      end
      want = expected_results.pop_front();
      if (want.kind == KIND_WORD) words_checked++;
      else summaries_checked++;
      compare("kind",           want.kind,           kind);
      compare("final_of_run",   want.final_of_run,   last);
      compare("word_index",     want.word_index,     data[6:0]);
      compare("word_value",     want.word_value,     data[22:7]);
      compare("resp_func",      want.resp_func,      data[30:23]);
      compare("status",         want.status,         data[32:31]);
      compare("exc_bit",        want.exc_bit,        data[33]);
      compare("exc_value",      want.exc_value,      data[41:34]);
      compare("data_len",       want.data_len,       data[49:42]);
      compare("register_count", want.register_count, data[56:50]);
      compare("echo_address",   want.echo_address,   data[72:57]);
      compare("echo_value",     want.echo_value,     data[88:73]);
      compare("padding",        '0,                  data[95:89]);
    endfunction
  endclass

endpackage

// ===== sim/tb_top.sv =====
// Top-level testbench for the Modbus response PDU parser.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mbrp_pkg::*;
  import tb_mbrp_scoreboard_pkg::*;

  localparam int          IDLE_LIMIT       = 4000;
  localparam int          LONG_HOLD_CYCLES = 300;
  localparam int          RANDOM_BYTES     = 1800;
  localparam int          DRAIN_CYCLES     = 10;
  localparam logic [7:0]  EXC_FLAG         = 8'h80;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [7:0]            in_tdata;
  logic                  in_tlast;
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;

  pdu_scoreboard sb;
  logic [7:0]    frame_buf[$];
  bit            sender_burst;
  bit            hold_request;
  int            bytes_sent  = 0;
  int            frames_sent = 0;
  int            idle_cycles = 0;

  modbus_response_pdu_parser_top #(
    .MAX_PDU_BYTES(PDU_LIMIT)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Offers one input word after a random gap and waits for it to be taken.
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    gap = sender_burst ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    sb.note_byte(b, last);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic send_frame();
    for (int i = 0; i < frame_buf.size(); i++) send_byte(frame_buf[i], i == frame_buf.size() - 1);
    frames_sent++;
  endtask

  // Mostly well-formed responses with random content, plus short, long and junk frames.
  task automatic build_random_frame(input int frame_no);
    int         sel;
    int         r;
    int         count;
    int         len;
    logic [7:0] fcode;
    frame_buf.delete();
    if (frame_no == 2 || frame_no == 5) begin
      // Largest read; the second one runs past the storage limit.
      fcode = $urandom_range(0, 1) ? FC_READ_HOLDING : FC_READ_INPUT;
      count = 254;
      len   = (frame_no == 2) ? PDU_LIMIT : PDU_LIMIT + 6;
    end else begin
      sel = $urandom_range(0, 99);
      if (sel < 40) begin
        fcode = $urandom_range(0, 1) ? FC_READ_HOLDING : FC_READ_INPUT;
        count = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 40) : 2 * $urandom_range(0, 8);
        r     = $urandom_range(0, 9);
        if (r < 7) len = 2 + count;
        else if (r < 9) len = $urandom_range(1, 2 + count);
        else len = 2 + count + $urandom_range(1, 4);
      end else if (sel < 60) begin
        fcode = $urandom_range(0, 1) ? FC_WRITE_COIL : FC_WRITE_REG;
        count = $urandom_range(0, 255);
        len   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 8) : int'(SINGLE_LEN);
      end else if (sel < 75) begin
        fcode = {1'b1, 7'($urandom_range(0, 127))};
        count = $urandom_range(0, 255);
        len   = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 5) : int'(HDR_LEN);
      end else begin
        fcode = 8'($urandom_range(0, 255));
        count = $urandom_range(0, 255);
        len   = $urandom_range(1, 12);
      end
    end
    frame_buf.push_back(fcode);
    for (int i = 1; i < len; i++)
      frame_buf.push_back((i == 1) ? 8'(count) : 8'($urandom_range(0, 255)));
  endtask

  // Stimulus and end of run.
  initial begin
    int frame_no;
    sb           = new();
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tlast     = 1'b0;
    rst_n        = 1'b0;
    sender_burst = 1'b0;
    hold_request = 1'b0;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Good read of two registers with extreme data values.
    frame_buf = '{FC_READ_HOLDING, 8'h04, 8'h00, 8'hFF, 8'hFF, 8'h00};
    send_frame();
    // Odd byte count: no register words, status too short.
    frame_buf = '{FC_READ_INPUT, 8'h03, 8'h11, 8'h22, 8'h33};
    send_frame();
    // Read cut short after its first register.
    frame_buf = '{FC_READ_INPUT, 8'h04, 8'h12, 8'h34, 8'h56};
    send_frame();
    // Data past the byte count is ignored.
    frame_buf = '{FC_READ_HOLDING, 8'h02, 8'hAB, 8'hCD, 8'hEF};
    send_frame();
    // Full single register write echo.
    frame_buf = '{FC_WRITE_REG, 8'hFF, 8'h00, 8'h00, 8'hFF};
    send_frame();
    // Single coil write that ends too early.
    frame_buf = '{FC_WRITE_COIL, 8'h12};
    send_frame();
    // Exception response.
    frame_buf = '{FC_READ_HOLDING | EXC_FLAG, 8'h02};
    send_frame();
    // Unknown function code.
    frame_buf = '{8'h00, 8'hFF};
    send_frame();
    // One-byte frame with the top bit of the code set.
    frame_buf = '{8'hFF};
    send_frame();

    // Random part; the output side stalls for a long stretch right at its start.
    hold_request = 1'b1;
    frame_no     = 0;
    while (bytes_sent < RANDOM_BYTES + 33) begin
      sender_burst = ($urandom_range(0, 3) == 0);
      build_random_frame(frame_no);
      send_frame();
      frame_no++;
    end
    in_tvalid <= 1'b0;

    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d bytes in %0d frames; checked %0d register words and %0d summaries.",
             bytes_sent, frames_sent, sb.words_checked, sb.summaries_checked);
    $display("Covered good, short and odd-count reads, writes, exceptions, unknown codes, %s",
             "oversized frames, random gaps and a long output stall.");
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Output side: random stalls per word, bursts without stalls, and one long hold.
  initial begin
    int stall;
    int served;
    bit rx_burst;
    out_tready = 1'b0;
    served     = 0;
    rx_burst   = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
      end
      if (served % 24 == 0) rx_burst = ($urandom_range(0, 2) == 0);
      stall = rx_burst ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      served++;
      @(negedge clk);
    end
  end

  // Every accepted output word goes to the scoreboard.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata, out_tuser, out_tlast);
  end

  // Ends the run if neither channel moves a word for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Timeout: no handshake for %0d cycles, %0d results outstanding.",
               idle_cycles, sb.expected_results.size());
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

// ===== sim.f =====
sv/mbrp_pkg.sv
sv/mbrp_parse.sv
sv/modbus_response_pdu_parser_top.sv
sim/tb_mbrp_scoreboard_pkg.sv
sim/tb_top.sv
